[rtl/wsfr_pkg.sv]
// Shared types, codes and helper functions of the WebSocket frame receiver.
`default_nettype none

package wsfr_pkg;

    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_BINARY = 3'd1;
    localparam logic [2:0] KIND_PING   = 3'd2;
    localparam logic [2:0] KIND_PONG   = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;

    localparam logic [1:0] FRAG_NONE   = 2'd0;
    localparam logic [1:0] FRAG_TEXT   = 2'd1;
    localparam logic [1:0] FRAG_BINARY = 2'd2;

    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [6:0] MAX_CTRL_LEN = 7'd125;

    localparam logic [15:0] CLOSE_NORMAL   = 16'd1000;
    localparam logic [15:0] CLOSE_PROTOCOL = 16'd1002;
    localparam logic [15:0] CLOSE_TOO_BIG  = 16'd1009;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        frame_last;
        logic        message_last;
        logic        close_event;
        logic [15:0] close_code;
        logic        close_local;
        logic        run_last;
    } result_t;

    function automatic logic [2:0] frame_kind(input logic [3:0] opcode,
                                              input logic [1:0] frag);
        logic [2:0] k;
        case (opcode)
            OP_TEXT:   k = KIND_TEXT;
            OP_BINARY: k = KIND_BINARY;
            OP_PING:   k = KIND_PING;
            OP_PONG:   k = KIND_PONG;
            OP_CLOSE:  k = KIND_CLOSE;
            default:   k = (frag == FRAG_TEXT) ? KIND_TEXT : KIND_BINARY;
        endcase
        return k;
    endfunction

    function automatic result_t local_close(input logic [15:0] code);
        result_t r;
        r = '0;
        r.kind        = KIND_CLOSE;
        r.close_event = 1'b1;
        r.close_code  = code;
        r.close_local = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/wsfr_parser.sv]
// Frame header parser, payload unmasker and link state of the receiver.
`default_nettype none

module wsfr_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              in_accept,
    input  wire logic              in_func,
    input  wire logic [7:0]        in_byte,
    output wsfr_pkg::result_t      res0,
    output wsfr_pkg::result_t      res1,
    output logic [1:0]             res_count
);

    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_LEN1 = 3'd2;
    localparam logic [2:0] PH_LEN0 = 3'd3;
    localparam logic [2:0] PH_KEY  = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;

    logic        use_mask_reg;
    logic        link_open_reg, link_open_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        fin_reg, fin_next;
    logic        masked_reg, masked_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] bcnt_reg, bcnt_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  frag_reg, frag_next;
    logic [15:0] acc_reg, acc_next;

    logic        h_fin, h_m, h_known, h_valid;
    logic [2:0]  h_rsv;
    logic [3:0]  h_op;
    logic [6:0]  h_len;
    logic [15:0] bcnt_inc;
    logic [7:0]  d;
    logic        last;
    logic        do_after_len, do_start, do_finish;

    always_comb begin
        h_fin   = hdr_reg[7];
        h_rsv   = hdr_reg[6:4];
        h_op    = hdr_reg[3:0];
        h_m     = in_byte[7];
        h_len   = in_byte[6:0];
        h_known = h_op inside {wsfr_pkg::OP_CONT, wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BINARY,
                               wsfr_pkg::OP_CLOSE, wsfr_pkg::OP_PING, wsfr_pkg::OP_PONG};
        h_valid = (h_rsv == 3'd0) && h_known &&
                  (!h_op[3] || (h_fin && h_len <= wsfr_pkg::MAX_CTRL_LEN));
        bcnt_inc = bcnt_reg + 16'd1;
        d = in_byte ^ (masked_reg ? key_reg[8 * (3 - bcnt_reg[1:0]) +: 8] : 8'd0);
        last = ({1'b0, bcnt_reg} + 17'd1) == {1'b0, plen_reg};
    end

    always_comb begin
        link_open_next = link_open_reg;
        phase_next     = phase_reg;
        hdr_next       = hdr_reg;
        opcode_next    = opcode_reg;
        fin_next       = fin_reg;
        masked_next    = masked_reg;
        plen_next      = plen_reg;
        bcnt_next      = bcnt_reg;
        key_next       = key_reg;
        frag_next      = frag_reg;
        acc_next       = acc_reg;
        res0           = '0;
        res1           = '0;
        res_count      = 2'd0;
        do_after_len   = 1'b0;
        do_start       = 1'b0;
        do_finish      = 1'b0;

        if (in_accept && in_func) begin
            link_open_next = 1'b1;
            phase_next     = PH_HDR1;
            frag_next      = wsfr_pkg::FRAG_NONE;
            bcnt_next      = 16'd0;
            acc_next       = wsfr_pkg::CLOSE_NORMAL;
        end else if (in_accept && link_open_reg) begin
            case (phase_reg)
                PH_HDR1: begin
                    hdr_next   = in_byte;
                    phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    if (!h_valid || h_m == use_mask_reg ||
                        ((h_op == wsfr_pkg::OP_TEXT || h_op == wsfr_pkg::OP_BINARY) &&
                         frag_reg != wsfr_pkg::FRAG_NONE && h_len != wsfr_pkg::LEN_EXT64) ||
                        (h_op == wsfr_pkg::OP_CONT && frag_reg == wsfr_pkg::FRAG_NONE &&
                         h_len != wsfr_pkg::LEN_EXT64)) begin
                        res0 = wsfr_pkg::local_close(wsfr_pkg::CLOSE_PROTOCOL);
                        res_count = 2'd1;
                        link_open_next = 1'b0;
                        phase_next = PH_HDR1;
                    end else if (h_len == wsfr_pkg::LEN_EXT64) begin
                        res0 = wsfr_pkg::local_close(wsfr_pkg::CLOSE_TOO_BIG);
                        res_count = 2'd1;
                        link_open_next = 1'b0;
                        phase_next = PH_HDR1;
                    end else begin
                        opcode_next = h_op;
                        fin_next    = h_fin;
                        masked_next = h_m;
                        if ((h_op == wsfr_pkg::OP_TEXT || h_op == wsfr_pkg::OP_BINARY) &&
                            !h_fin) begin
                            frag_next = h_op[1:0];
                        end
                        acc_next  = wsfr_pkg::CLOSE_NORMAL;
                        bcnt_next = 16'd0;
                        key_next  = 32'd0;
                        if (h_len == wsfr_pkg::LEN_EXT16) begin
                            plen_next  = 16'd0;
                            phase_next = PH_LEN1;
                        end else begin
                            plen_next    = {9'd0, h_len};
                            do_after_len = 1'b1;
                        end
                    end
                end
                PH_LEN1: begin
                    plen_next  = {in_byte, 8'd0};
                    phase_next = PH_LEN0;
                end
                PH_LEN0: begin
                    plen_next    = {plen_reg[15:8], in_byte};
                    do_after_len = 1'b1;
                end
                PH_KEY: begin
                    key_next  = {key_reg[23:0], in_byte};
                    bcnt_next = bcnt_inc;
                    if (bcnt_inc >= 16'd4) begin
                        do_start = 1'b1;
                    end
                end
                PH_DATA: begin
                    bcnt_next = bcnt_inc;
                    if (opcode_reg == wsfr_pkg::OP_CLOSE) begin
                        if (bcnt_reg < 16'd2) begin
                            if (plen_reg >= 16'd2) begin
                                if (bcnt_reg == 16'd0) begin
                                    acc_next = {d, 8'd0};
                                end else begin
                                    acc_next = {acc_reg[15:8], acc_reg[7:0] | d};
                                end
                            end
                        end else begin
                            res0.kind      = wsfr_pkg::KIND_CLOSE;
                            res0.data_byte = d;
                            res0.has_data  = 1'b1;
                            res_count      = 2'd1;
                        end
                        do_finish = last;
                    end else begin
                        res0.kind         = wsfr_pkg::frame_kind(opcode_reg, frag_reg);
                        res0.data_byte    = d;
                        res0.has_data     = 1'b1;
                        res0.frame_last   = last;
                        res0.message_last = last && (opcode_reg[3] || fin_reg);
                        res_count         = 2'd1;
                        if (last) begin
                            if (opcode_reg == wsfr_pkg::OP_CONT && fin_reg) begin
                                frag_next = wsfr_pkg::FRAG_NONE;
                            end
                            phase_next = PH_HDR1;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HDR1;
                end
            endcase

            if (do_after_len) begin
                if (masked_next) begin
                    phase_next = PH_KEY;
                    bcnt_next  = 16'd0;
                    key_next   = 32'd0;
                end else begin
                    do_start = 1'b1;
                end
            end
            if (do_start) begin
                bcnt_next = 16'd0;
                if (plen_next == 16'd0) begin
                    do_finish = 1'b1;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            if (do_finish) begin
                res1 = '0;
                res1.frame_last   = 1'b1;
                res1.message_last = 1'b1;
                if (opcode_next == wsfr_pkg::OP_CLOSE) begin
                    res1.kind        = wsfr_pkg::KIND_CLOSE;
                    res1.close_event = 1'b1;
                    res1.close_code  = acc_next;
                    link_open_next   = 1'b0;
                end else begin
                    res1.kind         = wsfr_pkg::frame_kind(opcode_next, frag_next);
                    res1.message_last = opcode_next[3] || fin_next;
                    if (opcode_next == wsfr_pkg::OP_CONT && fin_next) begin
                        frag_next = wsfr_pkg::FRAG_NONE;
                    end
                end
                phase_next = PH_HDR1;
                if (res_count == 2'd0) begin
                    res0 = res1;
                    res1 = '0;
                    res_count = 2'd1;
                end else begin
                    res_count = 2'd2;
                end
            end
            if (res_count == 2'd2) begin
                res1.run_last = 1'b1;
            end else if (res_count == 2'd1) begin
                res0.run_last = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_mask_reg  <= 1'b1;
            link_open_reg <= 1'b0;
            phase_reg     <= PH_HDR1;
            hdr_reg       <= 8'd0;
            opcode_reg    <= wsfr_pkg::OP_CONT;
            fin_reg       <= 1'b0;
            masked_reg    <= 1'b0;
            plen_reg      <= 16'd0;
            bcnt_reg      <= 16'd0;
            key_reg       <= 32'd0;
            frag_reg      <= wsfr_pkg::FRAG_NONE;
            acc_reg       <= wsfr_pkg::CLOSE_NORMAL;
        end else begin
            if (cfg_we) begin
                use_mask_reg <= cfg_wdata;
            end
            link_open_reg <= link_open_next;
            phase_reg     <= phase_next;
            hdr_reg       <= hdr_next;
            opcode_reg    <= opcode_next;
            fin_reg       <= fin_next;
            masked_reg    <= masked_next;
            plen_reg      <= plen_next;
            bcnt_reg      <= bcnt_next;
            key_reg       <= key_next;
            frag_reg      <= frag_next;
            acc_reg       <= acc_next;
        end
    end

`ifndef SYNTHESIS
    a_two_only_close: assert property (@(posedge aclk) disable iff (!aresetn)
        res_count == 2'd2 |-> opcode_reg == wsfr_pkg::OP_CLOSE && phase_reg == PH_DATA)
        else $error("two results outside a close frame payload");
    a_closed_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !in_func && !link_open_reg |-> res_count == 2'd0)
        else $error("result produced while the link is closed");
    a_local_close_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && res_count != 2'd0 && res0.close_event && res0.close_local
        |=> !link_open_reg && phase_reg == PH_HDR1)
        else $error("link still open after a local close");
`endif

endmodule

`default_nettype wire

[rtl/wsfr_out_queue.sv]
// Small result queue that takes up to two results per cycle and sends one while out_ready is high.
`default_nettype none

module wsfr_out_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire wsfr_pkg::result_t push0,
    input  wire wsfr_pkg::result_t push1,
    input  wire logic [1:0]        push_count,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wsfr_pkg::result_t      out_data
);

    wsfr_pkg::result_t mem_reg [wsfr_pkg::QUEUE_DEPTH];

    logic [wsfr_pkg::QUEUE_PTR_W-1:0] wr_reg, wr_next;
    logic [wsfr_pkg::QUEUE_PTR_W-1:0] rd_reg, rd_next;
    logic [wsfr_pkg::QUEUE_PTR_W-1:0] wr_plus1;
    logic [wsfr_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                             pop;

    always_comb begin
        pop       = out_valid && out_ready;
        wr_plus1  = wsfr_pkg::QUEUE_PTR_W'(wr_reg + 1'b1);
        wr_next   = wsfr_pkg::QUEUE_PTR_W'(wr_reg + push_count);
        rd_next   = pop ? wsfr_pkg::QUEUE_PTR_W'(rd_reg + 1'b1) : rd_reg;
        cnt_next  = wsfr_pkg::QUEUE_CNT_W'(cnt_reg + push_count - {1'b0, pop});
        room      = cnt_reg <= wsfr_pkg::QUEUE_CNT_W'(wsfr_pkg::QUEUE_DEPTH - 2);
        out_valid = cnt_reg != '0;
        out_data  = mem_reg[rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/websocket_frame_receiver_unit.sv]
// Top level of the WebSocket frame receiver with its stream ports.
`default_nettype none

// Takes one received connection byte per cycle and emits unmasked payload bytes
// tagged by message kind, frame and message end markers, and close events with
// their status code. A request is accepted in every cycle while the four-entry
// result queue has at least two free slots, so the sustained rate is one byte
// per cycle; the last payload byte of a close frame with at least three payload
// bytes yields two results, which the output side sends one after the other.
// A result is registered in the result queue before it is visible on the output.
module websocket_frame_receiver_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,     // use_mask
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // in_byte[7:0]
    input  wire logic [0:0]  s_tuser,       // func[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // data_byte[7:0], has_data[8], frame_last[9],
                                            // message_last[10], close_event[11],
                                            // close_code[27:12], close_local[28], zero[31:29]
    output logic [2:0]       m_tuser,       // kind[2:0]
    output logic             m_tlast        // run_last
);

    wsfr_pkg::result_t res0, res1, head;
    logic [1:0]        res_count;
    logic              room;

    assign s_tready = room;

    wsfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (s_tvalid && room),
        .in_func   (s_tuser[0]),
        .in_byte   (s_tdata),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    wsfr_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push0      (res0),
        .push1      (res1),
        .push_count (res_count),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (head)
    );

    assign m_tdata = {3'd0, head.close_local, head.close_code, head.close_event,
                      head.message_last, head.frame_last, head.has_data, head.data_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_last;

endmodule

`default_nettype wire
